### hw/rtl/depth_to_point_backproject_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef DEPTH_TO_POINT_BACKPROJECT_MACROS_SVH
`define DEPTH_TO_POINT_BACKPROJECT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define DTPB_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("dtpb: check failed");

// Next-cycle implication, checked outside reset
`define DTPB_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("dtpb: check failed");

`endif

### hw/rtl/dtpb_pkg.sv
`timescale 1ns / 1ps
package dtpb_pkg;

  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;

  // magnitude of 16*pos - center, divisor 2q, dividend 2*z*mag*16 + q
  localparam int MAG_W = 17;
  localparam int DIV_W = 17;
  localparam int DVD_W = 39;
  localparam int N_CELLS = DVD_W;

  localparam logic [2:0] REG_WIDTH    = 3'd0;
  localparam logic [2:0] REG_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_FOCAL_X  = 3'd2;
  localparam logic [2:0] REG_FOCAL_Y  = 3'd3;
  localparam logic [2:0] REG_CENTER_X = 3'd4;
  localparam logic [2:0] REG_CENTER_Y = 3'd5;

  typedef struct packed {
    logic             neg;
    logic [DIV_W-1:0] dvs;
    logic [DIV_W-1:0] rem;
    logic [DVD_W-1:0] dvd;
  } axis_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] z;
    axis_t       ax;
    axis_t       ay;
  } cell_t;

endpackage

### hw/rtl/dtpb_front.sv
`timescale 1ns / 1ps
module dtpb_front import dtpb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [15:0] depth_mm,
  input  logic        frame_start,
  input  logic [12:0] image_width,
  input  logic [12:0] image_height,
  input  logic [15:0] focal_x,
  input  logic [15:0] focal_y,
  input  logic [15:0] center_x,
  input  logic [15:0] center_y,
  output cell_t       head
);

  logic [11:0] column_count, row_count;
  logic [12:0] w, h;
  logic [11:0] col_cur, row_cur;
  logic [12:0] col_inc, row_inc;
  logic [12:0] pos_x, pos_y;
  logic signed [17:0] num_x, num_y;

  // stage A registers
  logic             va;
  logic [15:0]      za;
  logic             nx, ny;
  logic [MAG_W-1:0] mx, my;
  logic [15:0]      qx, qy;

  // clamp sizes and locate the pixel
  always_comb begin
    w = (image_width == '0) ? 13'd1 :
        (image_width > 13'(MaxWidth)) ? 13'(MaxWidth) : image_width;
    h = (image_height == '0) ? 13'd1 :
        (image_height > 13'(MaxHeight)) ? 13'(MaxHeight) : image_height;
    col_cur = frame_start ? '0 : column_count;
    row_cur = frame_start ? '0 : row_count;
    if ({1'b0, col_cur} >= w) col_cur = '0;
    if ({1'b0, row_cur} >= h) row_cur = '0;
    col_inc = {1'b0, col_cur} + 13'd1;
    row_inc = {1'b0, row_cur} + 13'd1;
    pos_x = {1'b0, col_cur} + {1'b0, w[12:1]};
    pos_y = {1'b0, row_cur} + {1'b0, h[12:1]};
    num_x = $signed({1'b0, pos_x, 4'b0}) - $signed({2'b0, center_x});
    num_y = $signed({1'b0, pos_y, 4'b0}) - $signed({2'b0, center_y});
  end

  // advance counters on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (en && in_valid) begin
      if (col_inc >= w) begin
        column_count <= '0;
        row_count    <= (row_inc >= h) ? '0 : row_inc[11:0];
      end else begin
        column_count <= col_inc[11:0];
        row_count    <= row_cur;
      end
    end
  end

  // stage A: signed offsets to magnitude and sign
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      za <= depth_mm;
      nx <= num_x[17];
      ny <= num_y[17];
      mx <= num_x[17] ? MAG_W'(-num_x) : num_x[MAG_W-1:0];
      my <= num_y[17] ? MAG_W'(-num_y) : num_y[MAG_W-1:0];
      qx <= (focal_x == '0) ? 16'd1 : focal_x;
      qy <= (focal_y == '0) ? 16'd1 : focal_y;
    end
  end

  // stage B: multiply and form rounded dividend 32*z*mag + q over 2q
  logic [32:0] px, py;
  assign px = 33'(za) * 33'(mx);
  assign py = 33'(za) * 33'(my);

  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else if (en) begin
      head.valid  <= va;
      head.z      <= za;
      head.ax.neg <= nx;
      head.ax.dvs <= {qx, 1'b0};
      head.ax.rem <= '0;
      head.ax.dvd <= {1'b0, px, 5'b0} + {23'b0, qx};
      head.ay.neg <= ny;
      head.ay.dvs <= {qy, 1'b0};
      head.ay.rem <= '0;
      head.ay.dvd <= {1'b0, py, 5'b0} + {23'b0, qy};
    end
  end

endmodule

### hw/rtl/dtpb_cell.sv
`timescale 1ns / 1ps
module dtpb_cell import dtpb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  cell_t prev,
  output cell_t next
);

  function automatic axis_t step(axis_t a);
    logic [DIV_W:0] r;
    logic           ge;
    axis_t          o;
    r  = {a.rem, a.dvd[DVD_W-1]};
    ge = r >= {1'b0, a.dvs};
    o  = a;
    o.rem = ge ? DIV_W'(r - {1'b0, a.dvs}) : r[DIV_W-1:0];
    o.dvd = {a.dvd[DVD_W-2:0], ge};
    return o;
  endfunction

  // one restoring quotient bit per axis
  always_ff @(posedge clk) begin
    if (rst) begin
      next.valid <= 1'b0;
    end else if (en) begin
      next.valid <= prev.valid;
      next.z     <= prev.z;
      next.ax    <= step(prev.ax);
      next.ay    <= step(prev.ay);
    end
  end

endmodule

### hw/rtl/depth_to_point_backproject.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload
// s_axis   in   tdata: depth_mm[15:0]; tuser: frame_start
// m_axis   out  tdata: point_x[31:0], point_y[63:32], point_z[79:64]
// cfg      in   cfg_we, cfg_index (register number), cfg_data[15:0]
// The pipeline has 42 register stages: offset stage, multiply stage, 39 divider cells, output.
// One request is taken per cycle unless the pipeline is halted; the chain of divider cells sets the latency.
// The whole pipeline halts while a result waits in the output register.
// Zero depth travels through and is dropped at the output.
// rst is synchronous and clears counters, valid bits and configuration registers to defaults.
`include "depth_to_point_backproject_macros.svh"
module depth_to_point_backproject import dtpb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // depth_mm
  input  logic        s_tuser,   // frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // point_x, point_y, point_z
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [12:0] image_width, image_height;
  logic [15:0] focal_x, focal_y, center_x, center_y;
  logic        en;
  cell_t       chain [N_CELLS+1];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd640;
      image_height <= 13'd480;
      focal_x      <= 16'd9600;
      focal_y      <= 16'd9600;
      center_x     <= 16'd5120;
      center_y     <= 16'd3840;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:    image_width  <= cfg_data[12:0];
        REG_HEIGHT:   image_height <= cfg_data[12:0];
        REG_FOCAL_X:  focal_x      <= cfg_data;
        REG_FOCAL_Y:  focal_y      <= cfg_data;
        REG_CENTER_X: center_x     <= cfg_data;
        REG_CENTER_Y: center_y     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  dtpb_front u_front (
    .clk, .rst, .en,
    .in_valid(s_tvalid), .depth_mm(s_tdata), .frame_start(s_tuser),
    .image_width, .image_height, .focal_x, .focal_y, .center_x, .center_y,
    .head(chain[0])
  );

  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    dtpb_cell u_cell (.clk, .rst, .en, .prev(chain[i]), .next(chain[i+1]));
  end

  function automatic logic [31:0] sat(logic neg, logic [DVD_W-1:0] r);
    logic [31:0] o;
    if (neg) o = (r > DVD_W'(64'h8000_0000)) ? 32'h8000_0000 : 32'(-r);
    else     o = (r > DVD_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : r[31:0];
    return o;
  endfunction

  // hold the result until taken; drop zero depth
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= chain[N_CELLS].valid && (chain[N_CELLS].z != '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {chain[N_CELLS].z,
                  sat(chain[N_CELLS].ay.neg, chain[N_CELLS].ay.dvd),
                  sat(chain[N_CELLS].ax.neg, chain[N_CELLS].ax.dvd)};
    end
  end

  `DTPB_ASSERT_NOW(a_no_zero_point, m_tvalid, m_tdata[79:64] != 16'd0)
  `DTPB_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `DTPB_ASSERT_NEXT(a_chain_frozen, !en, $stable(chain[N_CELLS].valid))

endmodule
